// ----- hdl/xrbg_pkg.sv -----
`default_nettype none

package xrbg_pkg;

    // request actions
    localparam logic [1:0] ACT_RESEED = 2'd0;
    localparam logic [1:0] ACT_RAW    = 2'd1;
    localparam logic [1:0] ACT_ALPHA  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SEED_X = 2'd0;
    localparam logic [1:0] REG_SEED_Y = 2'd1;
    localparam logic [1:0] REG_SEED_Z = 2'd2;
    localparam logic [1:0] REG_SEED_W = 2'd3;

    // xorshift128 shift amounts
    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 8;
    localparam int SHIFT_C = 19;

    localparam logic [31:0] SEED_X_RST = 32'd123456789;
    localparam logic [31:0] SEED_Y_RST = 32'd362436069;
    localparam logic [31:0] SEED_Z_RST = 32'd521288629;
    localparam logic [31:0] SEED_W_RST = 32'd88675123;

    // alphabet: 'a'..'w' then '0'..'8'
    localparam logic [4:0] ALPHA_LETTERS = 5'd23;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       final_byte;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_EMIT
    } xrbg_state_t;

    typedef struct packed {
        logic reseed;    // load state words from seed registers
        logic load_req;  // capture saturated length of a new request
        logic draw;      // step the generator, latch the drawn word
        logic advance;   // current byte delivered
    } xrbg_cmd_t;

    typedef struct packed {
        logic req_reseed;  // pending request is a reseed
        logic req_run;     // pending request emits at least one byte
        logic chunk_done;  // current byte is the last one from this word
        logic last_byte;   // current byte is the last one of the request
    } xrbg_status_t;

    function automatic logic [7:0] alpha_char(input logic [4:0] idx);
        logic [7:0] ch;
        if (idx < ALPHA_LETTERS)
            ch = CHAR_LOWER_A + {3'b000, idx};
        else
            ch = CHAR_DIGIT_0 + {3'b000, idx - ALPHA_LETTERS};
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xrbg_ctrl.sv -----
`default_nettype none

module xrbg_ctrl
    import xrbg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         out_stall,
    input  wire xrbg_status_t status,
    output xrbg_cmd_t         cmd,
    output logic              in_stall,
    output logic              out_valid
);

    xrbg_state_t state_reg;
    xrbg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.req_run)
                    state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (status.last_byte)
                        state_next = ST_IDLE;
                    else if (status.chunk_done)
                        state_next = ST_DRAW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.reseed   = in_valid && status.req_reseed;
                cmd.load_req = in_valid && status.req_run;
            end
            ST_DRAW:
            begin
                cmd.draw = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.advance = !out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/xrbg_datapath.sv -----
`default_nettype none

module xrbg_datapath
    import xrbg_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire xrbg_cmd_t    cmd,
    input  wire in_item_t     in_data,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    output xrbg_status_t      status,
    output out_item_t         out_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [31:0] seed_x_reg, seed_y_reg, seed_z_reg, seed_w_reg;
    logic [31:0] word_x_reg, word_y_reg, word_z_reg, word_w_reg;
    logic [31:0] word_w_next;
    logic [31:0] t_a, t_b;

    logic [31:0]      drawn_reg;
    logic [LEN_W-1:0] left_reg;
    logic [LEN_W-1:0] left_next;
    logic [6:0]       left_wide;
    logic [1:0]       pos_reg;
    logic [1:0]       last_reg;
    logic [1:0]       last_next;
    logic             alpha_reg;
    logic             tail_reg;
    logic             tail_next;
    logic [7:0]       sel_byte;

    // seed registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_x_reg <= SEED_X_RST;
            seed_y_reg <= SEED_Y_RST;
            seed_z_reg <= SEED_Z_RST;
            seed_w_reg <= SEED_W_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED_X: seed_x_reg <= cfg_data;
                REG_SEED_Y: seed_y_reg <= cfg_data;
                REG_SEED_Z: seed_z_reg <= cfg_data;
                REG_SEED_W: seed_w_reg <= cfg_data;
                default:    seed_x_reg <= seed_x_reg;
            endcase
        end
    end

    // one xorshift128 step
    always_comb
    begin
        t_a         = word_x_reg ^ (word_x_reg << SHIFT_A);
        t_b         = t_a ^ (t_a >> SHIFT_B);
        word_w_next = word_w_reg ^ (word_w_reg >> SHIFT_C) ^ t_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_x_reg <= SEED_X_RST;
            word_y_reg <= SEED_Y_RST;
            word_z_reg <= SEED_Z_RST;
            word_w_reg <= SEED_W_RST;
        end
        else if (cmd.reseed)
        begin
            word_x_reg <= seed_x_reg;
            word_y_reg <= seed_y_reg;
            word_z_reg <= seed_z_reg;
            word_w_reg <= seed_w_reg;
        end
        else if (cmd.draw)
        begin
            word_x_reg <= word_y_reg;
            word_y_reg <= word_z_reg;
            word_z_reg <= word_w_reg;
            word_w_reg <= word_w_next;
        end
    end

    // saturate request length
    always_comb
    begin
        if (in_data.byte_count > 7'(MAX_LEN))
            left_next = LEN_W'(MAX_LEN);
        else
            left_next = in_data.byte_count[LEN_W-1:0];
    end

    assign left_wide = 7'(left_reg);

    // bytes taken from the next word: four while four remain, else the tail rule
    always_comb
    begin
        tail_next = 1'b0;
        if (left_wide >= 7'd4)
            last_next = 2'd3;
        else if (alpha_reg)
        begin
            last_next = 2'd0;
            tail_next = 1'b1;
        end
        else if (left_wide >= 7'd2)
            last_next = 2'd1;
        else
            last_next = 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            left_reg  <= left_next;
            alpha_reg <= (in_data.action == ACT_ALPHA);
        end
        else if (cmd.advance)
            left_reg <= left_reg - LEN_W'(1);

        if (cmd.draw)
        begin
            drawn_reg <= word_w_next;
            pos_reg   <= 2'd0;
            last_reg  <= last_next;
            tail_reg  <= tail_next;
        end
        else if (cmd.advance)
            pos_reg <= pos_reg + 2'd1;
    end

    assign sel_byte = drawn_reg[8*pos_reg +: 8];

    always_comb
    begin
        if (!alpha_reg)
            out_data.out_byte = sel_byte;
        else if (tail_reg)
            out_data.out_byte = alpha_char(drawn_reg[4:0]);
        else
            out_data.out_byte = alpha_char(sel_byte[7:3]);
        out_data.final_byte = (left_reg == LEN_W'(1));
    end

    always_comb
    begin
        status.req_reseed = (in_data.action == ACT_RESEED);
        status.req_run    = (in_data.action inside {ACT_RAW, ACT_ALPHA})
                            && (in_data.byte_count != 7'd0);
        status.chunk_done = (pos_reg == last_reg);
        status.last_byte  = (left_reg == LEN_W'(1));
    end

endmodule

`default_nettype wire

// ----- hdl/xorshift_random_byte_generator.sv -----
// xorshift128 random byte source. A transaction on the input channel names an
// action and a length: reseed copies the four seed registers into the
// generator state and emits nothing, raw emits random bytes, alpha emits
// characters from a 32-symbol alphabet; lengths above MAX_LEN are clipped and
// a zero length or unknown action emits nothing. The last byte of a request
// carries final_byte. One request is served at a time and the input stalls
// until its last byte has been taken. Each generator word is drawn in the
// draw state and then supplies up to four bytes in the emit state, each one
// handed over only while the output is not stalled; a single xorshift step
// unit draws the words and the output byte mux picks each byte from its word.
// Seed registers may be written at any time the block is idle and take
// effect at the next reseed.
`default_nettype none

module xorshift_random_byte_generator
    import xrbg_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    xrbg_cmd_t    cmd;
    xrbg_status_t status;

    xrbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    xrbg_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_data  (out_data)
    );

    // no new request is taken while bytes are being emitted
    a_busy_while_emitting: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall
    ) else $error("input accepted while output active");

    // after the last byte of a request the output goes quiet
    a_idle_after_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.final_byte) |=> !out_valid
    ) else $error("output continued after final byte");

    // a request that emits bytes blocks the input in the following cycle
    a_stall_after_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.byte_count != 7'd0
            && (in_data.action == ACT_RAW || in_data.action == ACT_ALPHA))
        |=> in_stall
    ) else $error("request with bytes did not start");

    // reseed and empty requests emit nothing
    a_no_output_after_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall
            && (in_data.byte_count == 7'd0 || in_data.action == ACT_RESEED))
        |=> !out_valid
    ) else $error("output from a request without bytes");

endmodule

`default_nettype wire
